// ===== rtl/core/rau_pkg.sv =====
// Shared types, codes and constants of the rational arithmetic unit.
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int DW    = 2 * WIDTH;
    localparam int KW    = $clog2(DW);

    // Operation codes of the kind field.
    localparam logic [3:0] KIND_ADD = 4'd0;
    localparam logic [3:0] KIND_SUB = 4'd1;
    localparam logic [3:0] KIND_MUL = 4'd2;
    localparam logic [3:0] KIND_DIV = 4'd3;
    localparam logic [3:0] KIND_EQ  = 4'd4;
    localparam logic [3:0] KIND_NE  = 4'd5;
    localparam logic [3:0] KIND_LT  = 4'd6;
    localparam logic [3:0] KIND_GT  = 4'd7;
    localparam logic [3:0] KIND_LE  = 4'd8;
    localparam logic [3:0] KIND_GE  = 4'd9;
    localparam logic [3:0] KIND_INC = 4'd10;
    localparam logic [3:0] KIND_DEC = 4'd11;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    typedef struct packed {
        logic [3:0]              kind;
        logic signed [WIDTH-1:0] a_num;
        logic signed [WIDTH-1:0] a_den;
        logic signed [WIDTH-1:0] b_num;
        logic signed [WIDTH-1:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [WIDTH-1:0] res_num;
        logic [WIDTH-2:0]        res_den;
        logic                    compare_true;
        logic [1:0]              status;
    } out_item_t;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_IN,
        OP_LOAD_A,
        OP_LOAD_B,
        OP_GCD_START,
        OP_DIV_P,
        OP_DIV_Q,
        OP_TAKE_P,
        OP_TAKE_Q,
        OP_SAVE_A,
        OP_SAVE_B,
        OP_INCDEC,
        OP_MUL_T1,
        OP_MUL_T2,
        OP_ADDSUB,
        OP_MUL_P_NN,
        OP_MUL_P_NBD,
        OP_MUL_Q_DD,
        OP_MUL_Q_DN,
        OP_RES_FRAC,
        OP_RES_CMP,
        OP_RES_ERR
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] st;
    } dp_cmd_t;

    typedef struct packed {
        logic [3:0] kind;
        logic       a_den_zero;
        logic       b_den_zero;
        logic       b_num_zero;
        logic       gcd_busy;
        logic       div_busy;
    } dp_stat_t;

endpackage

// ===== rtl/core/rau_datapath.sv =====
// Datapath: operand registers, binary gcd unit, serial divider, multiplier, result register.
module rau_datapath
    import rau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output out_item_t out_data
);

    localparam logic [DW-1:0] LIM  = {{(DW-WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};
    localparam logic [DW-1:0] NLIM = LIM + 1'b1;

    logic [3:0]       kind_reg;
    logic [WIDTH-1:0] an_in_reg, ad_in_reg, bn_in_reg, bd_in_reg;
    logic [DW-1:0]    p_reg, q_reg;
    logic             pneg_reg;
    logic [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic             aneg_reg, bneg_reg;
    logic [DW-1:0]    t1_reg, t2_reg;
    logic [DW-1:0]    gx_reg, gy_reg;
    logic [KW-1:0]    gk_reg;
    logic             gbusy_reg;
    logic [DW-1:0]    rem_reg, quo_reg;
    logic [KW:0]      cnt_reg;
    logic             dbusy_reg;
    out_item_t        res_reg;

    logic [DW-1:0]    gcd_val;
    logic [DW:0]      rem_sh;
    logic             rem_ge;
    logic [WIDTH-1:0] mul_a, mul_b;
    logic [DW-1:0]    prod;
    logic [DW:0]      sum_incdec, sum_addsub;
    logic             t2neg;
    logic signed [DW-1:0] s1, s2;
    logic             cmp_res;
    logic             ovf;

    function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
        mag_of = v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    // Sign-magnitude add: result is {neg, mag}, zero is never negative.
    function automatic logic [DW:0] sm_add(input logic xn, input logic [DW-1:0] xm,
                                           input logic yn, input logic [DW-1:0] ym);
        logic          rn;
        logic [DW-1:0] rm;
        if (xn == yn) begin
            rn = xn;
            rm = xm + ym;
        end else if (xm >= ym) begin
            rn = xn;
            rm = xm - ym;
        end else begin
            rn = yn;
            rm = ym - xm;
        end
        if (rm == '0) begin
            rn = 1'b0;
        end
        sm_add = {rn, rm};
    endfunction

    assign gcd_val = gy_reg << gk_reg;
    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign rem_ge  = rem_sh >= {1'b0, gcd_val};

    // One shared multiplier, its product always lands in a register.
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (cmd.op)
            OP_MUL_T2:    begin mul_a = bn_reg; mul_b = ad_reg; end
            OP_MUL_P_NN:  begin mul_a = an_reg; mul_b = bn_reg; end
            OP_MUL_Q_DD:  begin mul_a = ad_reg; mul_b = bd_reg; end
            OP_MUL_Q_DN:  begin mul_a = ad_reg; mul_b = bn_reg; end
            default:      begin mul_a = an_reg; mul_b = bd_reg; end
        endcase
    end
    assign prod = mul_a * mul_b;

    assign sum_incdec = sm_add(aneg_reg, {{WIDTH{1'b0}}, an_reg},
                               kind_reg == KIND_DEC, {{WIDTH{1'b0}}, ad_reg});
    assign t2neg      = (kind_reg == KIND_SUB && t2_reg != '0) ? ~bneg_reg : bneg_reg;
    assign sum_addsub = sm_add(aneg_reg, t1_reg, t2neg, t2_reg);

    // Cross-products are at most 2^62, so a signed compare is exact.
    assign s1 = aneg_reg ? -$signed(t1_reg) : $signed(t1_reg);
    assign s2 = bneg_reg ? -$signed(t2_reg) : $signed(t2_reg);
    always_comb
    begin
        case (kind_reg)
            KIND_EQ: cmp_res = (s1 == s2);
            KIND_NE: cmp_res = (s1 != s2);
            KIND_LT: cmp_res = (s1 < s2);
            KIND_GT: cmp_res = (s1 > s2);
            KIND_LE: cmp_res = (s1 <= s2);
            default: cmp_res = (s1 >= s2);
        endcase
    end

    assign ovf = (p_reg > (pneg_reg ? NLIM : LIM)) || (q_reg > LIM);

    // Busy flags of the gcd unit and the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            if (cmd.op == OP_GCD_START) begin
                gbusy_reg <= 1'b1;
            end else if (gbusy_reg && gx_reg == '0) begin
                gbusy_reg <= 1'b0;
            end
            if (cmd.op == OP_DIV_P || cmd.op == OP_DIV_Q) begin
                dbusy_reg <= 1'b1;
                cnt_reg   <= (KW+1)'(DW);
            end else if (dbusy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == (KW+1)'(1)) begin
                    dbusy_reg <= 1'b0;
                end
            end
        end
    end

    // Binary gcd: one halving or subtraction per cycle until x reaches zero.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_GCD_START) begin
            gx_reg <= p_reg;
            gy_reg <= q_reg;
            gk_reg <= '0;
        end else if (gbusy_reg && gx_reg != '0) begin
            if (!gx_reg[0] && !gy_reg[0]) begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + 1'b1;
            end else if (!gx_reg[0]) begin
                gx_reg <= gx_reg >> 1;
            end else if (!gy_reg[0]) begin
                gy_reg <= gy_reg >> 1;
            end else if (gx_reg >= gy_reg) begin
                gx_reg <= gx_reg - gy_reg;
            end else begin
                gy_reg <= gy_reg - gx_reg;
            end
        end
    end

    // Restoring divider by the gcd, one quotient bit per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV_P || cmd.op == OP_DIV_Q) begin
            rem_reg <= '0;
            quo_reg <= (cmd.op == OP_DIV_P) ? p_reg : q_reg;
        end else if (dbusy_reg) begin
            rem_reg <= rem_ge ? DW'(rem_sh - {1'b0, gcd_val}) : rem_sh[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], rem_ge};
        end
    end

    // Operand, working and result registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD_IN: begin
                kind_reg  <= in_data.kind;
                an_in_reg <= in_data.a_num;
                ad_in_reg <= in_data.a_den;
                bn_in_reg <= in_data.b_num;
                bd_in_reg <= in_data.b_den;
            end
            OP_LOAD_A: begin
                p_reg    <= {{WIDTH{1'b0}}, mag_of(an_in_reg)};
                q_reg    <= {{WIDTH{1'b0}}, mag_of(ad_in_reg)};
                pneg_reg <= an_in_reg[WIDTH-1] ^ ad_in_reg[WIDTH-1];
            end
            OP_LOAD_B: begin
                p_reg    <= {{WIDTH{1'b0}}, mag_of(bn_in_reg)};
                q_reg    <= {{WIDTH{1'b0}}, mag_of(bd_in_reg)};
                pneg_reg <= bn_in_reg[WIDTH-1] ^ bd_in_reg[WIDTH-1];
            end
            OP_TAKE_P: begin
                p_reg    <= quo_reg;
                pneg_reg <= pneg_reg && quo_reg != '0;
            end
            OP_TAKE_Q: begin
                q_reg <= quo_reg;
            end
            OP_SAVE_A: begin
                an_reg   <= p_reg[WIDTH-1:0];
                ad_reg   <= q_reg[WIDTH-1:0];
                aneg_reg <= pneg_reg;
            end
            OP_SAVE_B: begin
                bn_reg   <= p_reg[WIDTH-1:0];
                bd_reg   <= q_reg[WIDTH-1:0];
                bneg_reg <= pneg_reg;
            end
            OP_INCDEC: begin
                p_reg    <= sum_incdec[DW-1:0];
                pneg_reg <= sum_incdec[DW];
                q_reg    <= {{WIDTH{1'b0}}, ad_reg};
            end
            OP_MUL_T1: begin
                t1_reg <= prod;
            end
            OP_MUL_T2: begin
                t2_reg <= prod;
            end
            OP_ADDSUB: begin
                p_reg    <= sum_addsub[DW-1:0];
                pneg_reg <= sum_addsub[DW];
            end
            OP_MUL_P_NN, OP_MUL_P_NBD: begin
                p_reg    <= prod;
                pneg_reg <= aneg_reg ^ bneg_reg;
            end
            OP_MUL_Q_DD, OP_MUL_Q_DN: begin
                q_reg <= prod;
            end
            OP_RES_FRAC: begin
                if (ovf) begin
                    res_reg <= '{res_num: '0, res_den: '0, compare_true: 1'b0, status: ST_OVF};
                end else begin
                    res_reg.res_num      <= pneg_reg ? -p_reg[WIDTH-1:0] : p_reg[WIDTH-1:0];
                    res_reg.res_den      <= q_reg[WIDTH-2:0];
                    res_reg.compare_true <= 1'b0;
                    res_reg.status       <= ST_OK;
                end
            end
            OP_RES_CMP: begin
                res_reg <= '{res_num: '0, res_den: '0, compare_true: cmp_res, status: ST_OK};
            end
            OP_RES_ERR: begin
                res_reg <= '{res_num: '0, res_den: '0, compare_true: 1'b0, status: cmd.st};
            end
            default: begin
            end
        endcase
    end

    assign stat.kind       = kind_reg;
    assign stat.a_den_zero = (ad_in_reg == '0);
    assign stat.b_den_zero = (bd_in_reg == '0);
    assign stat.b_num_zero = (bn_reg == '0);
    assign stat.gcd_busy   = gbusy_reg;
    assign stat.div_busy   = dbusy_reg;
    assign out_data        = res_reg;

endmodule

// ===== rtl/core/rau_ctrl.sv =====
// Controller: sequences normalization, the operation and result delivery.
module rau_ctrl
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_GCD, S_GWAIT, S_DIVP, S_PWAIT, S_DIVQ, S_QWAIT,
        S_RET, S_INCDEC, S_LOADB, S_OP, S_T2, S_ADD, S_QDD, S_EMIT
    } state_t;

    typedef enum logic [1:0] {PH_A, PH_B, PH_R} phase_t;

    state_t  state_reg, state_next;
    phase_t  phase_reg, phase_next;
    dp_cmd_t emit_reg, emit_next;
    logic    out_valid_reg, out_valid_next;
    logic    is_cmp;

    assign is_cmp = (stat.kind >= KIND_EQ) && (stat.kind <= KIND_GE);

    // Next state and datapath command.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        emit_next      = emit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '{op: OP_NONE, st: ST_OK};
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.op     = OP_LOAD_IN;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.kind > KIND_DEC) begin
                    emit_next  = '{op: OP_RES_ERR, st: ST_OK};
                    state_next = S_EMIT;
                end else if (stat.a_den_zero) begin
                    emit_next  = '{op: OP_RES_ERR, st: ST_ZDEN};
                    state_next = S_EMIT;
                end else begin
                    cmd.op     = OP_LOAD_A;
                    phase_next = PH_A;
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                cmd.op     = OP_GCD_START;
                state_next = S_GWAIT;
            end
            S_GWAIT: begin
                if (!stat.gcd_busy) begin
                    state_next = S_DIVP;
                end
            end
            S_DIVP: begin
                cmd.op     = OP_DIV_P;
                state_next = S_PWAIT;
            end
            S_PWAIT: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_TAKE_P;
                    state_next = S_DIVQ;
                end
            end
            S_DIVQ: begin
                cmd.op     = OP_DIV_Q;
                state_next = S_QWAIT;
            end
            S_QWAIT: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_TAKE_Q;
                    state_next = S_RET;
                end
            end
            S_RET: begin
                unique case (phase_reg)
                    PH_A: begin
                        cmd.op = OP_SAVE_A;
                        if (stat.kind == KIND_INC || stat.kind == KIND_DEC) begin
                            state_next = S_INCDEC;
                        end else if (stat.b_den_zero) begin
                            emit_next  = '{op: OP_RES_ERR, st: ST_ZDEN};
                            state_next = S_EMIT;
                        end else begin
                            state_next = S_LOADB;
                        end
                    end
                    PH_B: begin
                        cmd.op     = OP_SAVE_B;
                        state_next = S_OP;
                    end
                    default: begin
                        emit_next  = '{op: OP_RES_FRAC, st: ST_OK};
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_INCDEC: begin
                cmd.op     = OP_INCDEC;
                phase_next = PH_R;
                state_next = S_GCD;
            end
            S_LOADB: begin
                cmd.op     = OP_LOAD_B;
                phase_next = PH_B;
                state_next = S_GCD;
            end
            S_OP: begin
                phase_next = PH_R;
                case (stat.kind) inside
                    KIND_MUL: begin
                        cmd.op     = OP_MUL_P_NN;
                        state_next = S_QDD;
                    end
                    KIND_DIV: begin
                        if (stat.b_num_zero) begin
                            emit_next  = '{op: OP_RES_ERR, st: ST_DIV0};
                            state_next = S_EMIT;
                        end else begin
                            cmd.op     = OP_MUL_P_NBD;
                            state_next = S_QDD;
                        end
                    end
                    default: begin
                        cmd.op     = OP_MUL_T1;
                        state_next = S_T2;
                    end
                endcase
            end
            S_T2: begin
                cmd.op = OP_MUL_T2;
                if (is_cmp) begin
                    emit_next  = '{op: OP_RES_CMP, st: ST_OK};
                    state_next = S_EMIT;
                end else begin
                    state_next = S_ADD;
                end
            end
            S_ADD: begin
                cmd.op     = OP_ADDSUB;
                state_next = S_QDD;
            end
            S_QDD: begin
                cmd.op     = (stat.kind == KIND_DIV) ? OP_MUL_Q_DN : OP_MUL_Q_DD;
                state_next = S_GCD;
            end
            S_EMIT: begin
                if (!out_valid_reg || out_ready) begin
                    cmd            = emit_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_A;
            emit_reg      <= '{op: OP_NONE, st: ST_OK};
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: controller, datapath and checks.
// One beat in gives one beat out. Each fraction is reduced by a binary gcd loop
// and two passes of a one-bit-per-cycle restoring divider; the gcd loop does one
// halving or subtraction per cycle. An unused code or a zero denominator on a
// ends an item before any pass. Two-operand arithmetic takes two operand passes
// and one result pass, comparisons only the two operand passes, and inc/dec one
// operand pass and one result pass.
// A new beat is taken once the previous item has handed its result to the output
// register; the result waits there for out_ready.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rau_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

    // An error result carries no fraction and no compare outcome.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            out_data.res_num == '0 && out_data.res_den == '0 && !out_data.compare_true)
        else $error("error result with nonzero fields");

    // A compare outcome comes only with an all-zero fraction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.compare_true |->
            out_data.res_num == '0 && out_data.res_den == '0)
        else $error("compare result with a fraction");

    // An accepted beat keeps the unit busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("unit ready right after accepting a beat");

endmodule
